// File: rtl/core/shortest_job_first_pool_scheduler_top_defines.svh
// ----------------------------------------------------------------------------
// Shortest-job-first pool scheduler: assertion macros
// Shared check macros, sampled on the rising clock edge and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_JOB_FIRST_POOL_SCHEDULER_TOP_DEFINES_SVH
`define SHORTEST_JOB_FIRST_POOL_SCHEDULER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Check that a condition holds at every edge
`define SJFP_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("sjfp check failed");
// Check that a consequent holds in the cycle after the antecedent
`define SJFP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sjfp check failed");
`else
`define SJFP_ASSERT_ALWAYS(lbl, cond)
`define SJFP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/sjfp_pkg.sv
// ----------------------------------------------------------------------------
// Shortest-job-first pool scheduler package
// Job entry type, cell-row control type and result codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sjfp_pkg;

   // One stored job
   typedef struct packed {
      logic [7:0]  procs;
      logic [15:0] ticks;
      logic [15:0] number;
   } entry_type;

   // Row control: cells in [shift_lo, shift_hi) take their right neighbor,
   // cell load_idx takes the load word
   typedef struct packed {
      logic       shift;
      logic [7:0] shift_lo;
      logic [7:0] shift_hi;
      logic       load;
      logic [7:0] load_idx;
   } row_op_type;

   localparam logic FUNC_SUBMIT = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   localparam logic [2:0] KIND_QUEUED    = 3'd0;
   localparam logic [2:0] KIND_TOO_BIG   = 3'd1;
   localparam logic [2:0] KIND_WAIT_FULL = 3'd2;
   localparam logic [2:0] KIND_FINISHED  = 3'd3;
   localparam logic [2:0] KIND_STARTED   = 3'd4;
   localparam logic [2:0] KIND_NOT_START = 3'd5;
   localparam logic [2:0] KIND_WAIT_EMPTY = 3'd6;

   localparam logic [7:0] POOL_RESET = 8'd10;

endpackage

// File: rtl/core/sjfp_cell.sv
// ----------------------------------------------------------------------------
// Scheduler row cell
// Holds one job entry; loads a new entry or takes its right neighbor's.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sjfp_cell (
   input  logic                  clock,
   input  sjfp_pkg::row_op_type  op,
   input  logic [7:0]            cell_idx,
   input  sjfp_pkg::entry_type   right_entry,
   input  sjfp_pkg::entry_type   load_entry,
   output sjfp_pkg::entry_type   entry_ff
);

   sjfp_pkg::entry_type entry_in;

   // Pick load, shift or hold
   always_comb begin
      entry_in = entry_ff;
      if (op.load && (op.load_idx == cell_idx)) begin
         entry_in = load_entry;
      end else if (op.shift && (cell_idx >= op.shift_lo) && (cell_idx < op.shift_hi)) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: rtl/core/sjfp_row.sv
// ----------------------------------------------------------------------------
// Scheduler cell row
// A row of job cells that shift toward the head; cell 0 is the head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sjfp_row #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                  clock,
   input  sjfp_pkg::row_op_type  op,
   input  sjfp_pkg::entry_type   load_entry,
   output sjfp_pkg::entry_type   head
);

   sjfp_pkg::entry_type cells [DEPTH];

   // Build the row; the last cell sees the load word as its neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      sjfp_pkg::entry_type right;
      if (i == DEPTH - 1) begin : g_end
         assign right = load_entry;
      end else begin : g_mid
         assign right = cells[i + 1];
      end
      sjfp_cell u_cell (
         .clock       (clock),
         .op          (op),
         .cell_idx    (8'(i)),
         .right_entry (right),
         .load_entry  (load_entry),
         .entry_ff    (cells[i])
      );
   end

   assign head = cells[0];

endmodule

// File: rtl/core/shortest_job_first_pool_scheduler_top.sv
// ----------------------------------------------------------------------------
// Shortest-job-first pool scheduler
// Queues jobs, counts down running jobs and starts the shortest waiting job if it fits.
// ----------------------------------------------------------------------------
// Input words (req_) either submit a job (tuser 0) or advance one tick
// (tuser 1). Result words (rsp_) carry an event kind in tuser, the job
// number and the free processor count in tdata, and tlast on the final
// word of each input word. csr_ writes the pool size and reloads the free
// count from the processors held by running jobs; write it only when idle.
// A submit gives one word, registered in the cycle after acceptance.
// A tick walks the run row and the wait row together, one cell a cycle when
// the result register is free, and gives one word per finished job and one
// start word. The length of that walk over the two cell rows sets the rate;
// one item is worked at a time.
// Reset empties both rows, sets the pool to 10 and zeroes the numbering.
// A stalled receiver holds the result register and the walk waits for it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "shortest_job_first_pool_scheduler_top_defines.svh"

module shortest_job_first_pool_scheduler_top #(
   parameter int unsigned WAIT_DEPTH = 16,
   parameter int unsigned RUN_DEPTH  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // job_procs[7:0], job_ticks[23:8]
   input  logic [0:0]  req_tuser,   // func[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // job_number[15:0], free_after[23:16]
   output logic [2:0]  rsp_tuser,   // event_kind[2:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int unsigned RCW = $clog2(RUN_DEPTH + 1);
   localparam int unsigned WCW = $clog2(WAIT_DEPTH + 1);
   localparam int unsigned WIW = $clog2(WAIT_DEPTH);
   localparam int unsigned HW  = $clog2(RUN_DEPTH * 255 + 1);

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_START} state_type;

   state_type           state_ff;
   logic [7:0]          pool_ff;
   logic [7:0]          free_ff;
   logic [HW-1:0]       held_ff;
   logic [15:0]         next_ff;
   logic [WCW-1:0]      wc_ff;
   logic [RCW-1:0]      rc_ff;
   logic [RCW-1:0]      ru_ff;
   logic [WCW-1:0]      ws_ff;
   sjfp_pkg::entry_type best_ff;
   logic [WIW-1:0]      best_idx_ff;
   logic                rsp_valid_ff;
   logic [2:0]          rsp_kind_ff;
   logic [15:0]         rsp_num_ff;
   logic [7:0]          rsp_free_ff;
   logic                rsp_last_ff;

   sjfp_pkg::row_op_type run_op, wait_op;
   sjfp_pkg::entry_type  run_load, wait_load, run_head, wait_head;
   logic                 step_ok, req_fire, fits;
   logic [7:0]           in_procs;
   logic [15:0]          in_ticks;
   logic [8:0]           free_sum;
   logic [WCW-1:0]       scan_k;

   assign in_procs   = req_tdata[7:0];
   assign in_ticks   = req_tdata[23:8];
   assign step_ok    = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && step_ok;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = (state_ff == S_IDLE);
   assign fits       = (best_ff.procs <= free_ff) && (rc_ff < RCW'(RUN_DEPTH));
   assign free_sum   = {1'b0, free_ff} + {1'b0, run_head.procs};
   assign scan_k     = wc_ff - ws_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_free_ff, rsp_num_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Cell rows
   sjfp_row #(.DEPTH(RUN_DEPTH)) u_run_row (
      .clock      (clock),
      .op         (run_op),
      .load_entry (run_load),
      .head       (run_head)
   );

   sjfp_row #(.DEPTH(WAIT_DEPTH)) u_wait_row (
      .clock      (clock),
      .op         (wait_op),
      .load_entry (wait_load),
      .head       (wait_head)
   );

   // Drive row controls
   always_comb begin
      run_op          = '0;
      wait_op         = '0;
      run_load        = run_head;
      run_load.ticks  = run_head.ticks - 16'd1;
      wait_load       = wait_head;
      unique case (state_ff)
         S_IDLE: begin
            // Append a queued job at the tail
            if (req_fire && (req_tuser[0] == sjfp_pkg::FUNC_SUBMIT) &&
                (in_procs < pool_ff) && (wc_ff < WCW'(WAIT_DEPTH))) begin
               wait_op.load     = 1'b1;
               wait_op.load_idx = 8'(wc_ff);
               wait_load.procs  = in_procs;
               wait_load.ticks  = in_ticks;
               wait_load.number = next_ff;
            end
         end
         S_WALK: begin
            if (step_ok) begin
               // Pop the run head; put survivors back at the tail
               if (ru_ff != '0) begin
                  run_op.shift    = 1'b1;
                  run_op.shift_hi = 8'(rc_ff - RCW'(1));
                  if (run_head.ticks > 16'd1) begin
                     run_op.load     = 1'b1;
                     run_op.load_idx = 8'(rc_ff - RCW'(1));
                  end
               end
               // Rotate the wait row past the search
               if (ws_ff != '0) begin
                  wait_op.shift    = 1'b1;
                  wait_op.shift_hi = 8'(wc_ff - WCW'(1));
                  wait_op.load     = 1'b1;
                  wait_op.load_idx = 8'(wc_ff - WCW'(1));
               end
            end
         end
         S_START: begin
            // Move the chosen job from the wait row to the run row
            if (step_ok && (wc_ff != '0) && fits) begin
               run_op.load      = 1'b1;
               run_op.load_idx  = 8'(rc_ff);
               run_load         = best_ff;
               wait_op.shift    = 1'b1;
               wait_op.shift_lo = 8'(best_idx_ff);
               wait_op.shift_hi = 8'(wc_ff - WCW'(1));
            end
         end
         default: begin
         end
      endcase
   end

   // Control, counters and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pool_ff      <= sjfp_pkg::POOL_RESET;
         free_ff      <= sjfp_pkg::POOL_RESET;
         held_ff      <= '0;
         next_ff      <= '0;
         wc_ff        <= '0;
         rc_ff        <= '0;
         ru_ff        <= '0;
         ws_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         // Pool write reloads the free count
         if (csr_valid && csr_ready) begin
            pool_ff <= csr_data;
            free_ff <= (held_ff >= HW'(csr_data)) ? 8'd0 : 8'(HW'(csr_data) - held_ff);
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (req_tuser[0] == sjfp_pkg::FUNC_SUBMIT) begin
                     next_ff      <= next_ff + 16'd1;
                     rsp_valid_ff <= 1'b1;
                     rsp_num_ff   <= next_ff;
                     rsp_free_ff  <= free_ff;
                     rsp_last_ff  <= 1'b1;
                     if (in_procs >= pool_ff) begin
                        rsp_kind_ff <= sjfp_pkg::KIND_TOO_BIG;
                     end else if (wc_ff >= WCW'(WAIT_DEPTH)) begin
                        rsp_kind_ff <= sjfp_pkg::KIND_WAIT_FULL;
                     end else begin
                        rsp_kind_ff <= sjfp_pkg::KIND_QUEUED;
                        wc_ff       <= wc_ff + WCW'(1);
                     end
                  end else begin
                     ru_ff    <= rc_ff;
                     ws_ff    <= wc_ff;
                     state_ff <= S_WALK;
                  end
               end
            end
            S_WALK: begin
               if (step_ok) begin
                  if (ru_ff != '0) begin
                     ru_ff <= ru_ff - RCW'(1);
                     // Report and release a finished job
                     if (run_head.ticks <= 16'd1) begin
                        free_ff      <= free_sum[8] ? 8'hFF : free_sum[7:0];
                        held_ff      <= held_ff - HW'(run_head.procs);
                        rc_ff        <= rc_ff - RCW'(1);
                        rsp_valid_ff <= 1'b1;
                        rsp_kind_ff  <= sjfp_pkg::KIND_FINISHED;
                        rsp_num_ff   <= run_head.number;
                        rsp_free_ff  <= free_sum[8] ? 8'hFF : free_sum[7:0];
                        rsp_last_ff  <= 1'b0;
                     end
                  end
                  // Track the shortest, oldest waiting job
                  if (ws_ff != '0) begin
                     ws_ff <= ws_ff - WCW'(1);
                     if ((scan_k == '0) || (wait_head.ticks < best_ff.ticks)) begin
                        best_ff     <= wait_head;
                        best_idx_ff <= WIW'(scan_k);
                     end
                  end
               end
               if ((ru_ff == '0) && (ws_ff == '0)) begin
                  state_ff <= S_START;
               end
            end
            S_START: begin
               if (step_ok) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_last_ff  <= 1'b1;
                  rsp_free_ff  <= free_ff;
                  state_ff     <= S_IDLE;
                  if (wc_ff == '0) begin
                     rsp_kind_ff <= sjfp_pkg::KIND_WAIT_EMPTY;
                     rsp_num_ff  <= 16'd0;
                  end else if (fits) begin
                     rsp_kind_ff <= sjfp_pkg::KIND_STARTED;
                     rsp_num_ff  <= best_ff.number;
                     rsp_free_ff <= free_ff - best_ff.procs;
                     free_ff     <= free_ff - best_ff.procs;
                     held_ff     <= held_ff + HW'(best_ff.procs);
                     rc_ff       <= rc_ff + RCW'(1);
                     wc_ff       <= wc_ff - WCW'(1);
                  end else begin
                     rsp_kind_ff <= sjfp_pkg::KIND_NOT_START;
                     rsp_num_ff  <= best_ff.number;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Checks
   `SJFP_ASSERT_ALWAYS(a_wait_bound, wc_ff <= WCW'(WAIT_DEPTH))
   `SJFP_ASSERT_ALWAYS(a_run_bound, rc_ff <= RCW'(RUN_DEPTH))
   `SJFP_ASSERT_NEXT(a_start_word, (state_ff == S_START) && step_ok, rsp_valid_ff && rsp_last_ff)
   `SJFP_ASSERT_NEXT(a_submit_word, req_fire && (req_tuser[0] == sjfp_pkg::FUNC_SUBMIT), rsp_valid_ff && rsp_last_ff)

endmodule

// File: tb/tb_shortest_job_first_pool_scheduler_top.sv
// ----------------------------------------------------------------------------
// Shortest-job-first pool scheduler testbench
// Drives submit and tick words with random gaps and result stalls, predicts
// every result word from its own scheduler state and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_shortest_job_first_pool_scheduler_top;

   localparam int WAIT_SLOTS = 16;
   localparam int RUN_SLOTS  = 16;

   typedef struct {
      logic [2:0]  kind;
      logic [15:0] number;
      logic [7:0]  free_after;
      logic        last;
   } event_word_type;

   // Prediction of the scheduler and queue of expected result words
   class sched_board;
      sjfp_pkg::entry_type waiting[$];
      sjfp_pkg::entry_type running[$];
      logic [7:0]          pool;
      int unsigned         free_cnt;
      logic [15:0]         seq;
      event_word_type      pending[$];
      int                  errors;
      int                  words_seen;

      function void clear();
         waiting.delete();
         running.delete();
         pending.delete();
         pool = sjfp_pkg::POOL_RESET;
         free_cnt = sjfp_pkg::POOL_RESET;
         seq = 0;
         errors = 0;
         words_seen = 0;
      endfunction

      function void push(logic [2:0] k, logic [15:0] n, logic l);
         event_word_type ev;
         ev.kind = k;
         ev.number = n;
         ev.free_after = free_cnt[7:0];
         ev.last = l;
         pending = {pending, ev};
      endfunction

      function void set_pool(logic [7:0] value);
         int unsigned held;
         held = 0;
         pool = value;
         foreach (running[i]) held += running[i].procs;
         free_cnt = (held >= value) ? 0 : value - held;
      endfunction

      // Note an accepted input word and queue its result words
      function void note_input(logic func, logic [7:0] procs, logic [15:0] ticks);
         sjfp_pkg::entry_type ent;
         sjfp_pkg::entry_type kept[$];
         int                  best;
         logic [15:0]         num;
         if (func == sjfp_pkg::FUNC_SUBMIT) begin
            num = seq;
            seq = seq + 16'd1;
            if (procs >= pool) begin
               push(sjfp_pkg::KIND_TOO_BIG, num, 1'b1);
            end else if (waiting.size() >= WAIT_SLOTS) begin
               push(sjfp_pkg::KIND_WAIT_FULL, num, 1'b1);
            end else begin
               ent.procs = procs;
               ent.ticks = ticks;
               ent.number = num;
               waiting = {waiting, ent};
               push(sjfp_pkg::KIND_QUEUED, num, 1'b1);
            end
            return;
         end
         // count down running jobs, release finished ones in run order
         foreach (running[i]) begin
            ent = running[i];
            if (ent.ticks <= 1) begin
               free_cnt += ent.procs;
               if (free_cnt > 255) free_cnt = 255;
               push(sjfp_pkg::KIND_FINISHED, ent.number, 1'b0);
            end else begin
               ent.ticks = ent.ticks - 16'd1;
               kept = {kept, ent};
            end
         end
         running = kept;
         if (waiting.size() == 0) begin
            push(sjfp_pkg::KIND_WAIT_EMPTY, 16'd0, 1'b1);
            return;
         end
         best = 0;
         foreach (waiting[i])
            if (waiting[i].ticks < waiting[best].ticks) best = i;
         if (waiting[best].procs <= free_cnt && running.size() < RUN_SLOTS) begin
            ent = waiting[best];
            waiting.delete(best);
            running = {running, ent};
            free_cnt -= ent.procs;
            push(sjfp_pkg::KIND_STARTED, ent.number, 1'b1);
         end else begin
            push(sjfp_pkg::KIND_NOT_START, waiting[best].number, 1'b1);
         end
      endfunction

      task report(string what);
         $display("MISMATCH @%0t: %s", $realtime, what);
         errors++;
      endtask

      // Check one accepted result word against the oldest expectation
      task check_word(logic [2:0] k, logic [15:0] n, logic [7:0] f, logic l);
         event_word_type ev;
         words_seen++;
         if (pending.size() == 0) begin
            report($sformatf("unexpected word kind %0d job %0d", k, n));
            return;
         end
         ev = pending.pop_front();
         if (k !== ev.kind) report($sformatf("kind %0d want %0d", k, ev.kind));
         if (n !== ev.number) report($sformatf("job %0d want %0d", n, ev.number));
         if (f !== ev.free_after) report($sformatf("free %0d want %0d", f, ev.free_after));
         if (l !== ev.last) report($sformatf("last %0d want %0d", l, ev.last));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;

   sched_board board;
   bit         calm;
   int         submits;
   int         ticks_sent;

   shortest_job_first_pool_scheduler_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Receiver: random stall bursts, check every accepted word
   initial begin
      int hold;
      rsp_tready = 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            board.check_word(rsp_tuser, rsp_tdata[15:0], rsp_tdata[23:16], rsp_tlast);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Send one word, with an optional gap burst ahead of it; valid stays up
   // after acceptance until the next word, a gap or a drain replaces it
   task automatic send_word(input logic func, input logic [7:0] procs,
                            input logic [15:0] ticks);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {ticks, procs};
      do @(posedge clock); while (!req_tready);
      board.note_input(func, procs, ticks);
      if (func == sjfp_pkg::FUNC_SUBMIT) submits++; else ticks_sent++;
   endtask

   task automatic submit_job(input logic [7:0] procs, input logic [15:0] ticks);
      send_word(sjfp_pkg::FUNC_SUBMIT, procs, ticks);
   endtask

   task automatic tick_once();
      send_word(sjfp_pkg::FUNC_TICK, 8'($urandom), 16'($urandom));
   endtask

   // Drop valid, wait for all expected words, then let the walk settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_pool(input logic [7:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_pool(value);
      csr_valid <= 1'b0;
   endtask

   // Random traffic: submits mixed with ticks, mostly short jobs
   task automatic random_phase(input int count);
      logic [7:0]  p;
      logic [15:0] t;
      repeat (count) begin
         if ($urandom_range(0, 99) < 45) begin
            tick_once();
         end else begin
            p = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
            case ($urandom_range(0, 9))
               0:       t = 16'($urandom);
               1:       t = 16'hFFFF;
               default: t = 16'($urandom_range(0, 6));
            endcase
            submit_job(p, t);
         end
      end
   endtask

   initial begin
      board = new();
      board.clear();
      calm = 1'b0;
      submits = 0;
      ticks_sent = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty tick, limits, zero-tick job, equal ticks, fill the wait store
      tick_once();
      submit_job(8'd10, 16'd3);
      submit_job(8'd255, 16'd3);
      submit_job(8'd9, 16'd0);
      submit_job(8'd0, 16'hFFFF);
      submit_job(8'd3, 16'd2);
      submit_job(8'd2, 16'd2);
      tick_once();
      tick_once();
      tick_once();
      tick_once();
      repeat (17) submit_job(8'd1, 16'd1);
      repeat (4) tick_once();

      // Pool extremes and a mid value
      write_pool(8'd255);
      random_phase(20);
      write_pool(8'd0);
      submit_job(8'd0, 16'd1);
      tick_once();
      write_pool(8'd1);
      random_phase(10);
      write_pool(8'd12);
      random_phase(25);
      calm = 1'b1;
      random_phase(15);
      drain();

      $display("covered %0d submits and %0d ticks, %0d result words checked",
               submits, ticks_sent, board.words_seen);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: shortest_job_first_pool_scheduler_top.f
+incdir+rtl/core
rtl/core/sjfp_pkg.sv
rtl/core/sjfp_cell.sv
rtl/core/sjfp_row.sv
rtl/core/shortest_job_first_pool_scheduler_top.sv
tb/tb_shortest_job_first_pool_scheduler_top.sv
